// ===== rtl/core/websocket_client_frame_encoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// websocket client frame encoder assertion macros
// shared concurrent assertion forms, clocked on clk_i and idle during reset
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_CLIENT_FRAME_ENCODER_TOP_ASSERT_SVH
`define WEBSOCKET_CLIENT_FRAME_ENCODER_TOP_ASSERT_SVH

// condition must never hold
`define WSFE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define WSFE_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WSFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfe_pkg
// types, constants and helpers shared by the frame encoder modules
// ----------------------------------------------------------------------------
package wsfe_pkg;

  localparam int unsigned LenW  = 63;
  localparam int unsigned StepW = 4;

  localparam logic [7:0]      FinTextByte = 8'h81;
  localparam logic [7:0]      MaskBit     = 8'h80;
  localparam logic [6:0]      Len16Code   = 7'd126;
  localparam logic [6:0]      Len64Code   = 7'd127;
  localparam logic [LenW-1:0] ShortLimit  = LenW'(126);
  localparam logic [LenW-1:0] MidLimit    = LenW'(65536);
  localparam logic [31:0]     KeyReset    = 32'h1234_5678;

  // fixed header bytes: first byte, length byte, four key bytes
  localparam logic [StepW-1:0] BaseHdrN  = StepW'(6);
  localparam logic [StepW-1:0] MidLenN   = StepW'(2);
  localparam logic [StepW-1:0] LongLenN  = StepW'(8);

  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_SHORT,
    HDR_MID,
    HDR_LONG
  } hdr_kind_e;

  typedef enum logic [1:0] {
    PAY_NONE,
    PAY_DATA,
    PAY_OVERRUN
  } pay_kind_e;

  typedef struct packed {
    hdr_kind_e       hdr_kind;
    logic [LenW-1:0] len;
    logic            hdr_end;
    pay_kind_e       pay_kind;
    logic [7:0]      pay_byte;
    logic            pay_end;
  } item_desc_t;

  // key byte 0 sits in the top bits
  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/wsfe_front.sv =====
// ----------------------------------------------------------------------------
// wsfe_front
// accepts input items, tracks frame state and classifies each item
// ----------------------------------------------------------------------------
module wsfe_front import wsfe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     mask_key_i,
  input  logic [7:0]      data_byte_i,
  input  logic [LenW-1:0] frame_length_i,
  input  logic            starts_frame_i,
  input  logic            carries_data_i,
  input  logic            accept_i,
  output item_desc_t      desc_o,
  output logic            produce_o,
  output logic [31:0]     mask_key_o
);

  logic [31:0]     key_q;
  logic [1:0]      phase_q, phase_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic            in_frame_q, in_frame_d;

  logic [LenW-1:0] rem_eff;
  logic [1:0]      phase_eff;
  logic            in_frame_eff;
  logic            take;

  always_comb begin
    rem_eff      = starts_frame_i ? frame_length_i : rem_q;
    phase_eff    = starts_frame_i ? 2'd0 : phase_q;
    in_frame_eff = starts_frame_i ? (frame_length_i != '0) : in_frame_q;
    take         = carries_data_i && in_frame_eff && (rem_eff != '0);

    desc_o.len     = frame_length_i;
    desc_o.hdr_end = starts_frame_i && (frame_length_i == '0);
    priority if (!starts_frame_i) begin
      desc_o.hdr_kind = HDR_NONE;
    end else if (frame_length_i < ShortLimit) begin
      desc_o.hdr_kind = HDR_SHORT;
    end else if (frame_length_i < MidLimit) begin
      desc_o.hdr_kind = HDR_MID;
    end else begin
      desc_o.hdr_kind = HDR_LONG;
    end

    priority if (!carries_data_i) begin
      desc_o.pay_kind = PAY_NONE;
    end else if (take) begin
      desc_o.pay_kind = PAY_DATA;
    end else begin
      desc_o.pay_kind = PAY_OVERRUN;
    end
    desc_o.pay_byte = data_byte_i ^ key_byte(key_q, phase_eff);
    desc_o.pay_end  = (rem_eff == LenW'(1));

    // items with neither header nor payload cause no results
    produce_o = starts_frame_i || carries_data_i;

    rem_d      = rem_q;
    phase_d    = phase_q;
    in_frame_d = in_frame_q;
    if (accept_i) begin
      rem_d      = take ? rem_eff - LenW'(1) : rem_eff;
      phase_d    = take ? phase_eff + 2'd1 : phase_eff;
      in_frame_d = (take && desc_o.pay_end) ? 1'b0 : in_frame_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= KeyReset;
      phase_q    <= 2'd0;
      rem_q      <= '0;
      in_frame_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_q <= mask_key_i;
      end
      phase_q    <= phase_d;
      rem_q      <= rem_d;
      in_frame_q <= in_frame_d;
    end
  end

  assign mask_key_o = key_q;

endmodule

// ===== rtl/core/wsfe_fifo.sv =====
// ----------------------------------------------------------------------------
// wsfe_fifo
// short descriptor queue between the front and the back
// ----------------------------------------------------------------------------
`include "websocket_client_frame_encoder_top_assert.svh"

module wsfe_fifo import wsfe_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  item_desc_t desc_i,
  input  logic       pop_i,
  output item_desc_t desc_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_desc_t      entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign desc_o  = entries_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `WSFE_ASSERT_NEVER(fifo_count_ovf, count_q > CntW'(Depth), "queue count above depth")
  `WSFE_ASSERT_IMPLIES(fifo_empty_ptr, empty_o, rd_ptr_q == wr_ptr_q, "empty queue with pointers apart")
  `WSFE_ASSERT_NEXT(fifo_fill, do_push && !do_pop, count_q == $past(count_q) + CntW'(1), "push lost")

endmodule

// ===== rtl/core/wsfe_back.sv =====
// ----------------------------------------------------------------------------
// wsfe_back
// steps through one descriptor and presents its frame bytes in order
// ----------------------------------------------------------------------------
module wsfe_back import wsfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  item_desc_t  desc_i,
  input  logic [31:0] mask_key_i,
  input  logic        pop_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  output logic        overrun_o,
  output logic        last_of_item_o,
  output logic        done_o
);

  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] len_n, hdr_n, total_n, len_idx, key_idx;
  logic [6:0]       len_code;
  logic [63:0]      len_wide;
  logic             is_last;

  always_comb begin
    unique case (desc_i.hdr_kind)
      HDR_SHORT: begin
        len_n    = '0;
        len_code = desc_i.len[6:0];
      end
      HDR_MID: begin
        len_n    = MidLenN;
        len_code = Len16Code;
      end
      HDR_LONG: begin
        len_n    = LongLenN;
        len_code = Len64Code;
      end
      default: begin
        len_n    = '0;
        len_code = desc_i.len[6:0];
      end
    endcase
    hdr_n   = (desc_i.hdr_kind == HDR_NONE) ? '0 : BaseHdrN + len_n;
    total_n = hdr_n + ((desc_i.pay_kind == PAY_NONE) ? StepW'(0) : StepW'(1));
    is_last = (step_q == total_n - StepW'(1));

    len_wide = {1'b0, desc_i.len};
    // big-endian length: first length byte carries the top bits
    len_idx  = StepW'(1) + len_n - step_q;
    key_idx  = step_q - StepW'(2) - len_n;

    out_byte_o  = 8'h00;
    frame_end_o = 1'b0;
    overrun_o   = 1'b0;
    if (step_q < hdr_n) begin
      priority if (step_q == '0) begin
        out_byte_o = FinTextByte;
      end else if (step_q == StepW'(1)) begin
        out_byte_o = MaskBit | {1'b0, len_code};
      end else if (step_q < StepW'(2) + len_n) begin
        out_byte_o = len_wide[{len_idx[2:0], 3'b000} +: 8];
      end else begin
        out_byte_o = key_byte(mask_key_i, key_idx[1:0]);
      end
      frame_end_o = desc_i.hdr_end && (step_q == hdr_n - StepW'(1));
    end else begin
      out_byte_o  = (desc_i.pay_kind == PAY_DATA) ? desc_i.pay_byte : 8'h00;
      frame_end_o = (desc_i.pay_kind == PAY_DATA) && desc_i.pay_end;
      overrun_o   = (desc_i.pay_kind == PAY_OVERRUN);
    end

    last_of_item_o = is_last;
    done_o         = pop_i && is_last;
    step_d         = step_q;
    if (pop_i) begin
      step_d = is_last ? '0 : step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== rtl/core/websocket_client_frame_encoder_top.sv =====
// ----------------------------------------------------------------------------
// websocket_client_frame_encoder_top
// masked client text frame encoder with queue-style input and result ports
// ----------------------------------------------------------------------------
// usage:
//   input side: present an item and raise push; it transfers when full is low.
//   an opener item (starts_frame_i) yields the frame header and four key bytes,
//   plus one masked byte or overrun if carries_data_i is set; other data items yield one.
//   result side: while empty is low the oldest result byte is on the ports,
//   and it transfers on a cycle with pop high.
//   an item's first result shows once its descriptor is queued and at the head.
//   throughput: one payload item per cycle while pop is high; the back-end byte
//   sequencer holds the result side for 6, 8 or 14 opener bytes (+1 with data).
//   the front keeps accepting into a QueueDepth-entry descriptor queue while
//   the back emits header bytes, so full rises only when that queue fills.
//   a stalled receiver (pop low) holds the current byte and lets the queue fill;
//   nothing is dropped. reset: mask key returns to 0x12345678, frame state and
//   queue clear; no clearing pass. mask_key_i is to be written through cfg_we_i
//   only while idle; the user must keep to this, the block does not enforce it.
// ----------------------------------------------------------------------------
`include "websocket_client_frame_encoder_top_assert.svh"

module websocket_client_frame_encoder_top import wsfe_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     mask_key_i,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      data_byte_i,
  input  logic [LenW-1:0] frame_length_i,
  input  logic            starts_frame_i,
  input  logic            carries_data_i,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte_o,
  output logic            frame_end_o,
  output logic            overrun_o,
  output logic            last_of_item_o
);

  item_desc_t  front_desc, head_desc;
  logic        accept, produce;
  logic        pop_ok, done;
  logic [31:0] key;

  assign accept = push && !full;
  assign pop_ok = pop && !empty;

  wsfe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .mask_key_i     (mask_key_i),
    .data_byte_i    (data_byte_i),
    .frame_length_i (frame_length_i),
    .starts_frame_i (starts_frame_i),
    .carries_data_i (carries_data_i),
    .accept_i       (accept),
    .desc_o         (front_desc),
    .produce_o      (produce),
    .mask_key_o     (key)
  );

  wsfe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && produce),
    .desc_i  (front_desc),
    .pop_i   (done),
    .desc_o  (head_desc),
    .full_o  (full),
    .empty_o (empty)
  );

  wsfe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_i         (head_desc),
    .mask_key_i     (key),
    .pop_i          (pop_ok),
    .out_byte_o     (out_byte_o),
    .frame_end_o    (frame_end_o),
    .overrun_o      (overrun_o),
    .last_of_item_o (last_of_item_o),
    .done_o         (done)
  );

  `WSFE_ASSERT_NEVER(top_end_ovr, !empty && frame_end_o && overrun_o, "frame end on overrun")
  `WSFE_ASSERT_IMPLIES(top_ovr_last, !empty && overrun_o, out_byte_o == 8'h00 && last_of_item_o, "overrun result malformed")
  `WSFE_ASSERT_NEXT(top_item_cont, pop_ok && !last_of_item_o, !empty, "item results cut short")

endmodule
